FILE: rtl/dnfs_pkg.sv
package dnfs_pkg;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_TOP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION     = 3'd4;

  // Direction codes; anything above DIR_RIGHT matches nothing
  localparam int DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd4;

  // One pixel margin around the source extension lines, in 1/16 pixel units
  localparam int MARGIN_UNITS = 16;

  // Entries in the queue between the classify front and the select back
  localparam int QUEUE_DEPTH = 4;

endpackage

FILE: rtl/dnfs_queue.sv
module dnfs_queue
  import dnfs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/dnfs_front.sv
module dnfs_front
  import dnfs_pkg::*;
#(
  parameter int ID_BITS    = 8,
  parameter int COORD_BITS = 20
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // configuration writes
  input  logic                                      cfg_valid,
  input  logic [CFG_ADDR_W-1:0]                     cfg_addr,
  input  logic [COORD_BITS-1:0]                     cfg_data,
  // candidate stream
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((ID_BITS+6*COORD_BITS-2+7)/8)*8-1:0] in_tdata,
  input  logic                                      in_tlast,
  // classified record toward the queue
  output logic                                      rec_valid,
  input  logic                                      rec_ready,
  output logic [ID_BITS+2*(COORD_BITS+3)+2:0]       rec_data
);

  localparam int C  = COORD_BITS;
  localparam int D  = COORD_BITS + 3;   // doubled-coordinate difference
  localparam int O  = COORD_BITS + 2;   // overlap compare width
  localparam int AX_LO = ID_BITS;
  localparam int AY_LO = AX_LO + C;
  localparam int RL_LO = AY_LO + C;
  localparam int RT_LO = RL_LO + C;
  localparam int RW_LO = RT_LO + C;
  localparam int RH_LO = RW_LO + C - 1;
  localparam logic signed [O-1:0] MARGIN = O'(MARGIN_UNITS);

  // Configuration registers
  logic signed [C-1:0] src_left_r, src_top_r;
  logic [C-2:0]        src_width_r, src_height_r;
  logic [DIR_W-1:0]    dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_left_r   <= '0;
      src_top_r    <= '0;
      src_width_r  <= '0;
      src_height_r <= '0;
      dir_r        <= DIR_NONE;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_SOURCE_LEFT:   src_left_r   <= cfg_data;
        REG_SOURCE_TOP:    src_top_r    <= cfg_data;
        REG_SOURCE_WIDTH:  src_width_r  <= cfg_data[C-2:0];
        REG_SOURCE_HEIGHT: src_height_r <= cfg_data[C-2:0];
        REG_DIRECTION:     dir_r        <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Field unpack
  logic [ID_BITS-1:0]  id;
  logic signed [C-1:0] ax, ay, rl, rt;
  logic [C-2:0]        rw, rh;

  assign id = in_tdata[ID_BITS-1:0];
  assign ax = in_tdata[AX_LO +: C];
  assign ay = in_tdata[AY_LO +: C];
  assign rl = in_tdata[RL_LO +: C];
  assign rt = in_tdata[RT_LO +: C];
  assign rw = in_tdata[RW_LO +: C-1];
  assign rh = in_tdata[RH_LO +: C-1];

  // Cursor point at 1/32 pixel, anchor offset from it
  logic signed [D-1:0] sl_d, st_d, sw_d, sh_d, ax_d, ay_d;
  logic signed [D-1:0] cx2, cy2, dx2, dy2;
  logic                match;

  assign sl_d = {{3{src_left_r[C-1]}}, src_left_r};
  assign st_d = {{3{src_top_r[C-1]}}, src_top_r};
  assign sw_d = {4'b0, src_width_r};
  assign sh_d = {4'b0, src_height_r};
  assign ax_d = {{3{ax[C-1]}}, ax};
  assign ay_d = {{3{ay[C-1]}}, ay};

  always_comb begin
    unique case (dir_r)
      DIR_UP: begin
        cx2 = sl_d + sl_d + sw_d;
        cy2 = st_d + st_d;
      end
      DIR_DOWN: begin
        cx2 = sl_d + sl_d + sw_d;
        cy2 = st_d + st_d + sh_d + sh_d;
      end
      DIR_LEFT: begin
        cx2 = sl_d + sl_d;
        cy2 = st_d + st_d + sh_d;
      end
      DIR_RIGHT: begin
        cx2 = sl_d + sl_d + sw_d + sw_d;
        cy2 = st_d + st_d + sh_d;
      end
      default: begin
        cx2 = sl_d + sl_d + sw_d;
        cy2 = st_d + st_d + sh_d;
      end
    endcase
  end

  assign dx2 = ax_d + ax_d - cx2;
  assign dy2 = ay_d + ay_d - cy2;

  // Strictly beyond the cursor in the chosen direction
  always_comb begin
    unique case (dir_r)
      DIR_UP:    match = dy2[D-1];
      DIR_DOWN:  match = !dy2[D-1] && (dy2 != '0);
      DIR_LEFT:  match = dx2[D-1];
      DIR_RIGHT: match = !dx2[D-1] && (dx2 != '0);
      default:   match = 1'b0;
    endcase
  end

  // Overlap with the source extension lines, on the axis across the motion
  logic                vert;
  logic signed [O-1:0] s1, s2, t1, t2;
  logic                ovl;

  assign vert = (dir_r == DIR_UP) || (dir_r == DIR_DOWN);
  assign s1   = vert ? {{2{src_left_r[C-1]}}, src_left_r} : {{2{src_top_r[C-1]}}, src_top_r};
  assign s2   = s1 + (vert ? {3'b0, src_width_r} : {3'b0, src_height_r});
  assign t1   = vert ? {{2{rl[C-1]}}, rl} : {{2{rt[C-1]}}, rt};
  assign t2   = t1 + (vert ? {3'b0, rw} : {3'b0, rh});
  assign ovl  = ((t1 < s1 + MARGIN) && (s1 - MARGIN < t2)) ||
                ((t1 < s2 + MARGIN) && (s2 - MARGIN < t2));

  // Record: {id, dx2, dy2, match, overlap, last}
  assign rec_valid = in_tvalid;
  assign in_tready = rec_ready;
  assign rec_data  = {id, dx2, dy2, match, ovl, in_tlast};

endmodule

FILE: rtl/dnfs_back.sv
module dnfs_back
  import dnfs_pkg::*;
#(
  parameter int ID_BITS    = 8,
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // classified record from the queue
  input  logic                                rec_valid,
  output logic                                rec_ready,
  input  logic [ID_BITS+2*(COORD_BITS+3)+2:0] rec_data,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [ID_BITS-1:0]                  out_id
);

  localparam int D      = COORD_BITS + 3;
  localparam int M      = D - 1;               // magnitude bits
  localparam int SQ_W   = 2 * M;
  localparam int SUM_W  = SQ_W + 1;
  localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'({DIST_W{1'b1}});

  // Record unpack
  logic [ID_BITS-1:0]  r_id;
  logic signed [D-1:0] r_dx2, r_dy2;
  logic                r_match, r_ovl, r_last;

  assign r_last  = rec_data[0];
  assign r_ovl   = rec_data[1];
  assign r_match = rec_data[2];
  assign r_dy2   = rec_data[3 +: D];
  assign r_dx2   = rec_data[3+D +: D];
  assign r_id    = rec_data[3+2*D +: ID_BITS];

  // Stage 1: squares
  logic [M-1:0]       magx, magy;
  logic [SQ_W-1:0]    sqx, sqy;
  logic               s1_v_r;
  logic [SQ_W-1:0]    s1_sqx_r, s1_sqy_r;
  logic [ID_BITS-1:0] s1_id_r;
  logic               s1_match_r, s1_ovl_r, s1_last_r;
  logic               s1_adv, s2_fire, out_free;

  assign magx = r_dx2[D-1] ? M'(-r_dx2) : M'(r_dx2);
  assign magy = r_dy2[D-1] ? M'(-r_dy2) : M'(r_dy2);
  assign sqx  = magx * magx;
  assign sqy  = magy * magy;

  // A last record may only move on when the result register is free
  assign out_free  = !out_valid || out_ready;
  assign s2_fire   = s1_v_r && (!s1_last_r || out_free);
  assign s1_adv    = !s1_v_r || s2_fire;
  assign rec_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && rec_valid) begin
      s1_sqx_r   <= sqx;
      s1_sqy_r   <= sqy;
      s1_id_r    <= r_id;
      s1_match_r <= r_match;
      s1_ovl_r   <= r_ovl;
      s1_last_r  <= r_last;
    end
  end

  // Stage 2: saturating distance and best-so-far compare
  logic [SUM_W-1:0]   dsum;
  logic [DIST_W-1:0]  cand_dist;
  logic               best_valid_r, best_ovl_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [ID_BITS-1:0] best_id_r;
  logic               take;
  logic               nb_valid, nb_ovl;
  logic [DIST_W-1:0]  nb_dist;
  logic [ID_BITS-1:0] nb_id;

  assign dsum      = SUM_W'(s1_sqx_r) + SUM_W'(s1_sqy_r);
  assign cand_dist = (dsum > DIST_MAX) ? {DIST_W{1'b1}} : dsum[DIST_W-1:0];

  always_comb begin
    if (!best_valid_r) begin
      take = 1'b1;
    end else if (s1_ovl_r != best_ovl_r) begin
      take = s1_ovl_r;
    end else begin
      take = (cand_dist < best_dist_r);
    end
    nb_valid = best_valid_r;
    nb_ovl   = best_ovl_r;
    nb_dist  = best_dist_r;
    nb_id    = best_id_r;
    if (s1_match_r && take) begin
      nb_valid = 1'b1;
      nb_ovl   = s1_ovl_r;
      nb_dist  = cand_dist;
      nb_id    = s1_id_r;
    end
  end

  // Best-so-far update; cleared after the last record of a search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_ovl_r   <= 1'b0;
      best_dist_r  <= '0;
      best_id_r    <= '0;
    end else if (s2_fire) begin
      if (s1_last_r) begin
        best_valid_r <= 1'b0;
        best_ovl_r   <= 1'b0;
        best_dist_r  <= '0;
        best_id_r    <= '0;
      end else begin
        best_valid_r <= nb_valid;
        best_ovl_r   <= nb_ovl;
        best_dist_r  <= nb_dist;
        best_id_r    <= nb_id;
      end
    end
  end

  // Result register
  logic               out_valid_r;
  logic               out_found_r;
  logic [ID_BITS-1:0] out_id_r;
  logic               load_out;

  assign load_out = s2_fire && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= nb_valid;
      out_id_r    <= nb_valid ? nb_id : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_id    = out_id_r;

endmodule

FILE: rtl/directional_nearest_focus_select_core.sv
// Directional nearest-focus selector.
// Throughput: one candidate per cycle unless back-pressure stalls it; the classify front,
//   the queue and the two-stage select back each move one transaction per clock.
// A tlast candidate passes the queue and the stage-1 register before out_tvalid rises.
// Reset (rst_n, synchronous, active low): config returns to zero with direction none,
//   the queue empties and the search state and result register clear.
module directional_nearest_focus_select_core
  import dnfs_pkg::*;
#(
  parameter int ID_BITS    = 8,
  parameter int COORD_BITS = 20
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // configuration write channel
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [CFG_ADDR_W-1:0]                       cfg_addr,
  input  logic [COORD_BITS-1:0]                       cfg_data,
  // candidate stream
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // tdata, low bit up: candidate_id, anchor_x, anchor_y, rect_left, rect_top,
  //   rect_width, rect_height, zero fill
  input  logic [((ID_BITS+6*COORD_BITS-2+7)/8)*8-1:0] in_tdata,
  input  logic                                        in_tlast,   // last_candidate
  // result stream
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [((ID_BITS+7)/8)*8-1:0]                out_tdata,  // winner_id, zero fill
  output logic                                        out_tuser   // found
);

  localparam int REC_W = ID_BITS + 2 * (COORD_BITS + 3) + 3;
  localparam int OUT_W = ((ID_BITS + 7) / 8) * 8;

  logic               q_wr_valid, q_wr_ready;
  logic [REC_W-1:0]   q_wr_data;
  logic               q_rd_valid, q_rd_ready;
  logic [REC_W-1:0]   q_rd_data;
  logic               out_found;
  logic [ID_BITS-1:0] out_id;

  assign cfg_ready = 1'b1;

  // Classify front: config registers, cursor, direction and overlap tests
  dnfs_front #(
    .ID_BITS    (ID_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .rec_valid (q_wr_valid),
    .rec_ready (q_wr_ready),
    .rec_data  (q_wr_data)
  );

  // Decoupling queue
  dnfs_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  // Select back: distance, best-so-far, result register
  dnfs_back #(
    .ID_BITS    (ID_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_rd_valid),
    .rec_ready (q_rd_ready),
    .rec_data  (q_rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (out_found),
    .out_id    (out_id)
  );

  assign out_tuser = out_found;
  assign out_tdata = OUT_W'(out_id);

  // An accepted candidate is in the queue at the next edge
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> q_rd_valid)
    else $error("accepted candidate missing from queue");

  // The queue head stays while the back end is stalled
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_rd_valid && !q_rd_ready) |=> (q_rd_valid && $stable(q_rd_data)))
    else $error("queue head changed under stall");

  // No winner id without a match
  a_no_id_unfound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser || (out_tdata == '0)))
    else $error("winner id set while nothing found");

endmodule

FILE: tb/directional_nearest_focus_select_core_test.sv
`timescale 1ns / 1ps

module directional_nearest_focus_select_core_test;
  import dnfs_pkg::*;

  localparam int IDW = 8;
  localparam int CW = 20;
  localparam int TDATA_W = ((IDW + 6 * CW - 2 + 7) / 8) * 8;
  localparam int FILL_W = TDATA_W - (IDW + 6 * CW - 2);
  localparam int OUT_W = ((IDW + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd5;  // first index past the register list
  localparam logic [DIR_W-1:0] DIR_LAST_CODE = 3'd7;

  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int BURST_ITEMS = 40;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;

  typedef enum {SET_MIXED, SET_LOWEST, SET_HIGHEST} setting_kind_t;

  // Candidate fields as they sit in tdata, id in the low bits
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [CW-2:0] rh;
    logic [CW-2:0] rw;
    logic [CW-1:0] rt;
    logic [CW-1:0] rl;
    logic [CW-1:0] ay;
    logic [CW-1:0] ax;
    logic [IDW-1:0] id;
  } cand_bits_t;

  typedef struct {
    logic found;
    logic [IDW-1:0] win;
  } verdict_t;

  typedef struct {
    logic is_write;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CW-1:0] val;
    cand_bits_t cand;
    logic last;
    logic typed;
    logic found;
    logic [IDW-1:0] win;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CW-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  // Sideband that travels with each candidate: a hand-written verdict for the search
  logic tag_typed;
  logic tag_found;
  logic [IDW-1:0] tag_win;

  // Shadow of the block's registers and search state
  logic signed [CW-1:0] src_left, src_top;
  logic [CW-2:0] src_w, src_h;
  logic [DIR_W-1:0] src_dir;
  logic best_valid, best_near;
  longint unsigned best_dist;
  logic [IDW-1:0] best_id;

  verdict_t expected_verdicts[$];
  int mismatch_count = 0;

  // Stimulus control
  bit hold_req = 1'b0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  int aim_left, aim_top, aim_w, aim_h;
  cand_bits_t prev_cand = '0;
  int search_left = 0;
  script_row_t script[$];

  directional_nearest_focus_select_core #(
    .ID_BITS(IDW),
    .COORD_BITS(CW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Squares and their sum clamp at all ones
  function automatic longint unsigned square_sat(longint d);
    longint unsigned mag;
    mag = (d < 0) ? -d : d;
    if (mag > 64'hFFFF_FFFF) return '1;
    return mag * mag;
  endfunction

  function automatic longint unsigned sum_sat(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  // Does [t1, t2] reach within the margin of either extension line s1 or s2
  function automatic logic band_overlap(longint s1, longint s2, longint t1, longint t2);
    return (t1 < s1 + MARGIN_UNITS && s1 - MARGIN_UNITS < t2) ||
           (t1 < s2 + MARGIN_UNITS && s2 - MARGIN_UNITS < t2);
  endfunction

  // Fold one candidate into the running search; a last candidate yields the verdict
  function automatic void judge_candidate(cand_bits_t c, logic last, logic typed,
                                          logic tf, logic [IDW-1:0] tw);
    longint sl, st, sw, sh, cx2, cy2, dx2, dy2;
    longint unsigned cand_dist;
    logic hit, near, take;
    verdict_t v;
    sl = src_left;
    st = src_top;
    sw = src_w;
    sh = src_h;
    // Cursor at the midpoint of the facing edge, doubled coordinates
    case (src_dir)
      DIR_UP: begin cx2 = 2 * sl + sw; cy2 = 2 * st; end
      DIR_DOWN: begin cx2 = 2 * sl + sw; cy2 = 2 * st + 2 * sh; end
      DIR_LEFT: begin cx2 = 2 * sl; cy2 = 2 * st + sh; end
      DIR_RIGHT: begin cx2 = 2 * sl + 2 * sw; cy2 = 2 * st + sh; end
      default: begin cx2 = 2 * sl + sw; cy2 = 2 * st + sh; end
    endcase
    dx2 = 2 * longint'($signed(c.ax)) - cx2;
    dy2 = 2 * longint'($signed(c.ay)) - cy2;
    case (src_dir)
      DIR_UP: hit = dy2 < 0;
      DIR_DOWN: hit = dy2 > 0;
      DIR_LEFT: hit = dx2 < 0;
      DIR_RIGHT: hit = dx2 > 0;
      default: hit = 1'b0;
    endcase
    if (hit) begin
      if (src_dir == DIR_UP || src_dir == DIR_DOWN)
        near = band_overlap(sl, sl + sw, $signed(c.rl), $signed(c.rl) + longint'(c.rw));
      else
        near = band_overlap(st, st + sh, $signed(c.rt), $signed(c.rt) + longint'(c.rh));
      cand_dist = sum_sat(square_sat(dx2), square_sat(dy2));
      if (!best_valid) take = 1'b1;
      else if (near != best_near) take = near;
      else take = cand_dist < best_dist;
      if (take) begin
        best_valid = 1'b1;
        best_near = near;
        best_dist = cand_dist;
        best_id = c.id;
      end
    end
    if (last) begin
      if (typed) begin
        v.found = tf;
        v.win = tw;
      end else begin
        v.found = best_valid;
        v.win = best_valid ? best_id : '0;
      end
      expected_verdicts.push_back(v);
      best_valid = 1'b0;
      best_near = 1'b0;
      best_dist = 0;
      best_id = '0;
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $realtime, what);
  endtask

  // Monitor: register writes, accepted candidates and results, all at the clock edge
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      src_left = '0;
      src_top = '0;
      src_w = '0;
      src_h = '0;
      src_dir = DIR_NONE;
      best_valid = 1'b0;
      best_near = 1'b0;
      best_dist = 0;
      best_id = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_SOURCE_LEFT: src_left = cfg_data;
          REG_SOURCE_TOP: src_top = cfg_data;
          REG_SOURCE_WIDTH: src_w = cfg_data[CW-2:0];
          REG_SOURCE_HEIGHT: src_h = cfg_data[CW-2:0];
          REG_DIRECTION: src_dir = cfg_data[DIR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        judge_candidate(cand_bits_t'(in_tdata), in_tlast, tag_typed, tag_found, tag_win);
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b id=%0d", out_tuser, out_tdata));
        end else begin
          v = expected_verdicts.pop_front();
          if (out_tuser !== v.found || out_tdata !== OUT_W'(v.win))
            report_mismatch($sformatf("mismatch: expected found=%0b id=%0d, got found=%0b id=%0d",
                                      v.found, v.win, out_tuser, out_tdata));
        end
      end
    end
  end

  // Run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!receiver_calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(cand_bits_t b, logic last, logic typed, logic tf,
                           logic [IDW-1:0] tw);
    in_tdata <= b;
    in_tlast <= last;
    tag_typed <= typed;
    tag_found <= tf;
    tag_win <= tw;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!sender_calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CW-1:0] val);
    cfg_addr <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(setting_kind_t kind);
    int l, t, w, h, r;
    logic [DIR_W-1:0] d;
    settle();
    case (kind)
      SET_LOWEST: begin l = -524288; t = -524288; w = 0; h = 0; end
      SET_HIGHEST: begin l = 524287; t = 524287; w = 524287; h = 524287; end
      default: begin
        l = int'($urandom_range(0, 8000)) - 4000;
        t = int'($urandom_range(0, 8000)) - 4000;
        w = $urandom_range(0, 2000);
        h = $urandom_range(0, 2000);
      end
    endcase
    r = $urandom_range(0, 12);
    if (r < 9) d = DIR_UP + DIR_W'(r % 4);
    else d = DIR_NONE + DIR_W'(r - 9);
    aim_left = l;
    aim_top = t;
    aim_w = w;
    aim_h = h;
    write_reg(REG_SOURCE_LEFT, l[CW-1:0]);
    write_reg(REG_SOURCE_TOP, t[CW-1:0]);
    // top bit of the size writes is dropped by the block
    write_reg(REG_SOURCE_WIDTH, {1'($urandom), w[CW-2:0]});
    write_reg(REG_SOURCE_HEIGHT, {1'($urandom), h[CW-2:0]});
    write_reg(REG_DIRECTION, {(CW - DIR_W)'($urandom), d});
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_SPARE + CFG_ADDR_W'($urandom_range(0, 2)), CW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly candidates around the source, some raw noise, some repeated anchors
  function automatic cand_bits_t next_candidate();
    cand_bits_t c;
    int cx, cy, span_x, span_y, ax, ay;
    c = '0;
    if ($urandom_range(0, 9) < 3) begin
      c.id = $urandom;
      c.ax = $urandom;
      c.ay = $urandom;
      c.rl = $urandom;
      c.rt = $urandom;
      c.rw = $urandom;
      c.rh = $urandom;
    end else begin
      cx = aim_left + aim_w / 2;
      cy = aim_top + aim_h / 2;
      span_x = aim_w + 3000;
      span_y = aim_h + 3000;
      ax = cx - span_x + int'($urandom_range(0, 2 * span_x));
      ay = cy - span_y + int'($urandom_range(0, 2 * span_y));
      if ($urandom_range(0, 7) == 0) begin
        ax = $signed(prev_cand.ax);
        ay = $signed(prev_cand.ay);
      end
      c.id = $urandom;
      c.ax = ax[CW-1:0];
      c.ay = ay[CW-1:0];
      c.rl = CW'(ax - int'($urandom_range(0, 600)));
      c.rt = CW'(ay - int'($urandom_range(0, 600)));
      c.rw = ($urandom_range(0, 9) == 0) ? (CW - 1)'($urandom) : (CW - 1)'($urandom_range(0, 1200));
      c.rh = ($urandom_range(0, 9) == 0) ? (CW - 1)'($urandom) : (CW - 1)'($urandom_range(0, 1200));
    end
    prev_cand = c;
    return c;
  endfunction

  function automatic void add_write(logic [CFG_ADDR_W-1:0] idx, int val);
    script_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx = idx;
    r.val = val[CW-1:0];
    script.push_back(r);
  endfunction

  function automatic void add_cand(int id, int ax, int ay, int rl, int rt, int rw, int rh,
                                   bit last, bit typed, bit found, int win);
    script_row_t r;
    r = '{default: '0};
    r.cand.id = id[IDW-1:0];
    r.cand.ax = ax[CW-1:0];
    r.cand.ay = ay[CW-1:0];
    r.cand.rl = rl[CW-1:0];
    r.cand.rt = rt[CW-1:0];
    r.cand.rw = rw[CW-2:0];
    r.cand.rh = rh[CW-2:0];
    r.last = last;
    r.typed = typed;
    r.found = found;
    r.win = win[IDW-1:0];
    script.push_back(r);
  endfunction

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_addr <= REG_SOURCE_LEFT;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    tag_typed <= 1'b0;
    tag_found <= 1'b0;
    tag_win <= '0;

    // Directed searches; source is 10 px square at (20 px, 20 px) unless noted
    // out of reset the direction is none, so nothing matches
    add_cand(8'h5A, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_write(REG_SOURCE_LEFT, 320);
    add_write(REG_SOURCE_TOP, 320);
    add_write(REG_SOURCE_WIDTH, 160);
    add_write(REG_SOURCE_HEIGHT, 160);
    add_write(REG_DIRECTION, DIR_RIGHT);
    // anchor on the edge is not beyond it; one unit past is
    add_cand(1, 480, 400, 500, 320, 100, 100, 1, 1, 0, 0);
    add_cand(2, 481, 400, 500, 320, 100, 100, 1, 1, 1, 2);
    // overlapping far candidate beats a near one off the band
    add_cand(3, 2000, 400, 2000, 320, 50, 50, 0, 0, 0, 0);
    add_cand(4, 490, 400, 490, 10000, 10, 10, 1, 1, 1, 3);
    // equal distance keeps the earlier one
    add_cand(5, 600, 400, 600, 320, 40, 40, 0, 0, 0, 0);
    add_cand(6, 600, 400, 600, 330, 40, 40, 1, 1, 1, 5);
    // closer wins when both overlap
    add_cand(7, 700, 400, 700, 320, 40, 40, 0, 0, 0, 0);
    add_cand(8, 600, 400, 600, 320, 40, 40, 1, 1, 1, 8);
    // margin is strict on both sides of the band
    add_cand(9, 600, 400, 600, 496, 50, 10, 0, 0, 0, 0);
    add_cand(10, 3000, 400, 3000, 495, 50, 10, 1, 1, 1, 10);
    add_cand(11, 600, 400, 600, 294, 50, 10, 0, 0, 0, 0);
    add_cand(12, 3000, 400, 3000, 295, 50, 10, 1, 1, 1, 12);
    // remaining directions
    add_write(REG_DIRECTION, DIR_UP);
    add_cand(21, 400, 320, 320, 0, 160, 10, 0, 0, 0, 0);
    add_cand(20, 400, 319, 320, 0, 160, 10, 1, 1, 1, 20);
    add_write(REG_DIRECTION, DIR_DOWN);
    add_cand(30, 400, 481, 320, 600, 10, 10, 1, 1, 1, 30);
    add_write(REG_DIRECTION, DIR_LEFT);
    add_cand(40, 319, 400, 0, 320, 10, 10, 1, 1, 1, 40);
    // undefined direction code, and a write past the register list is dropped
    add_write(REG_DIRECTION, DIR_LAST_CODE);
    add_cand(50, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_write(REG_SPARE, DIR_RIGHT);
    add_cand(51, 481, 400, 481, 320, 10, 10, 1, 1, 0, 0);
    // direction changes in the middle of a search; kept best is not re-judged
    add_write(REG_DIRECTION, DIR_RIGHT);
    add_cand(60, 481, 400, 481, 320, 10, 10, 0, 0, 0, 0);
    add_write(REG_DIRECTION, DIR_LEFT);
    add_cand(61, 319, 400, 0, 320, 10, 10, 1, 1, 1, 60);
    // coordinate and size extremes
    add_write(REG_SOURCE_LEFT, -524288);
    add_write(REG_SOURCE_TOP, 524287);
    add_write(REG_SOURCE_WIDTH, 524287);
    add_write(REG_SOURCE_HEIGHT, 0);
    add_write(REG_DIRECTION, DIR_RIGHT);
    add_cand(255, 524287, -524288, -524288, 524287, 524287, 524287, 0, 0, 0, 0);
    add_cand(0, -1, 524287, -524288, -524288, 0, 0, 1, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle();
        write_reg(script[i].idx, script[i].val);
        cfg_valid <= 1'b0;
      end else begin
        send_item(script[i].cand, script[i].last, script[i].typed, script[i].found,
                  script[i].win);
      end
    end

    // Random searches under a new setting per phase; a search may span a setting change
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: apply_setting(SET_LOWEST);
        5: apply_setting(SET_HIGHEST);
        default: apply_setting(SET_MIXED);
      endcase
      receiver_calm = (ph == PHASES - 1);
      sender_calm = receiver_calm;
      if (ph == 3) begin
        // results back up behind a long hold-off until the input stalls
        hold_req = 1'b1;
        sender_calm = 1'b1;
        repeat (BURST_ITEMS) send_item(next_candidate(), 1'b1, 1'b0, 1'b0, '0);
        search_left = 0;
        sender_calm = 1'b0;
      end
      repeat (ITEMS_PER_PHASE) begin
        if (search_left == 0)
          search_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        search_left--;
        send_item(next_candidate(), search_left == 0, 1'b0, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
